[hdl/tgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types and codes of the exclusion-process event engine.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int DEF_MAX_SITES = 1024;
    localparam int DEF_RATE_BITS = 16;

    // request opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // reaction kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_HOP     = 3'd1;
    localparam logic [2:0] KIND_INIT    = 3'd2;
    localparam logic [2:0] KIND_RECYCLE = 3'd3;
    localparam logic [2:0] KIND_TERM    = 3'd4;
    localparam logic [2:0] KIND_OVER    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_ENTRY   = 3'd0;
    localparam logic [2:0] CFG_EXIT    = 3'd1;
    localparam logic [2:0] CFG_RECYCLE = 3'd2;
    localparam logic [2:0] CFG_GAP     = 3'd3;
    localparam logic [2:0] CFG_SITES   = 3'd4;
    localparam logic [2:0] CFG_END     = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_RD,
        ST_P_PD,
        ST_P_RT,
        ST_CHECK,
        ST_DIV,
        ST_HOP_WR,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS,
        ST_RF_RD0,
        ST_RF_RD1,
        ST_RF_CMP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[hdl/tgs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_div
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module tgs_div #(
    parameter int NW = 32,
    parameter int DW = 29
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);

    localparam int KW = $clog2(NW + 1);

    logic          r_busy;
    logic [KW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic          r_done;

    logic [DW:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[DW-1:0], r_q[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_q   <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[hdl/tasep_gillespie_event_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tasep_gillespie_event_step_unit
// Gillespie event engine for an exclusion process of extended particles.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   i_op, i_site_index, i_site_rate,        start & !busy
//            i_uniform_draw, i_exp_draw
//  result    o_reaction_kind .. o_run_done           o_valid, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         i_cfg_we
//
//  Write, start and unused requests go from idle straight to the done state.
//  A simulate request walks the particle memory twice (particle read, rate
//  table read for a free particle that can hop, accumulate), runs the serial
//  divider, then shifts entries down on a removal and makes up to three flag
//  refreshes.
//  Particles sit in a ring buffer, so an insertion at the front is one write.
//  Reset is synchronous; it clears control state, no memory pass is needed.
//  Results cannot be stalled; the next request may arrive while o_valid is up.
// ----------------------------------------------------------------------------
module tasep_gillespie_event_step_unit #(
    parameter int MAX_SITES = tgs_pkg::DEF_MAX_SITES,
    parameter int RATE_BITS = tgs_pkg::DEF_RATE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_site_index,
    input  wire logic [15:0] i_site_rate,
    input  wire logic [15:0] i_uniform_draw,
    input  wire logic [23:0] i_exp_draw,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_reaction_kind,
    output logic [10:0]      o_moved_position,
    output logic [10:0]      o_particle_count,
    output logic [31:0]      o_yield_total,
    output logic [47:0]      o_sim_time,
    output logic             o_run_done
);

    localparam int IW = $clog2(MAX_SITES);        // memory address
    localparam int CW = $clog2(MAX_SITES + 1);    // counts, indexes, positions
    localparam int RW = (RATE_BITS < 16) ? RATE_BITS : 16;
    localparam int TW = RW + $clog2(2 * MAX_SITES + 2);  // rate sums
    localparam int MW = TW + 16;                  // scaled uniform target

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    // configuration
    logic [15:0] r_entry_rate, r_exit_rate, r_recycle_rate;
    logic [5:0]  r_gap;
    logic [10:0] r_site_count;
    logic [47:0] r_end_time;

    // run state
    tgs_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [47:0]   r_time;
    logic [31:0]   r_yield;
    logic [IW-1:0] r_base;          // ring slot of particle 0

    // event working registers
    logic [15:0]   r_u;
    logic [23:0]   r_exp;
    logic          r_pass;          // 0 = sum total, 1 = pick reaction
    logic [CW-1:0] r_i;
    logic [TW-1:0] r_acc;
    logic [MW-1:0] r_target;
    logic          r_ec;            // entry clear
    logic [CW-1:0] r_cur_pos;
    logic          r_cur_free;
    logic [CW-1:0] r_p;
    logic [2:0]    r_kind;
    logic [10:0]   r_moved;
    logic [CW-1:0] r_rf_idx [3];
    logic [2:0]    r_rf_vld;
    logic [CW-1:0] r_rfi;

    // memories: particle ring {free, position} and site rate table
    logic [CW:0]   r_pmem [MAX_SITES];
    logic [CW:0]   r_pdata;
    logic [RW-1:0] r_rmem [MAX_SITES];
    logic [RW-1:0] r_rdata;

    logic          p_re, p_we, rt_re, rt_we;
    logic [IW-1:0] p_raddr, p_waddr, rt_raddr, rt_waddr;
    logic [CW:0]   p_wdata;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] b, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = (CW+1)'(b) + (CW+1)'(l);
        if (s >= (CW+1)'(MAX_SITES)) s = s - (CW+1)'(MAX_SITES);
        return s[IW-1:0];
    endfunction

    function automatic logic hit(input logic [MW-1:0] tgt, input logic [TW-1:0] cum);
        return tgt < {cum, 16'd0};
    endfunction

    // ---- derived values ----
    logic [CW-1:0] sc;
    logic [TW-1:0] entry_m, exit_m, rec_m;
    logic [CW-1:0] cur_pos;
    logic          cur_free;
    logic          ec_now;
    logic [TW-1:0] cum1, cum2, acc_rt, tail_add;
    logic          accept, at_end, hop_site;
    logic [IW-1:0] base_dec;
    logic [1:0]    rf_k;
    logic          rf_any;
    logic [CW-1:0] rf_sel;
    logic          sh_last;
    logic          free_cmp;
    logic          div_start, div_done;
    logic [31:0]   div_quot;
    logic [48:0]   time_sum;

    assign sc = (r_site_count == 11'd0) ? CW'(1) :
                (32'(r_site_count) > MAX_SITES) ? CW'(MAX_SITES) : CW'(r_site_count);
    assign entry_m  = TW'(r_entry_rate[RW-1:0]);
    assign exit_m   = TW'(r_exit_rate[RW-1:0]);
    assign rec_m    = TW'(r_recycle_rate[RW-1:0]);
    assign cur_pos  = r_pdata[CW-1:0];
    assign cur_free = r_pdata[CW];
    // the entry is clear once the first particle sits beyond the gap
    assign ec_now   = (r_i == '0) ? (32'(r_gap) < 32'(cur_pos)) : r_ec;
    assign cum1     = r_acc + exit_m;
    assign cum2     = cum1 + (ec_now ? rec_m : '0);
    assign acc_rt   = r_acc + TW'(r_rdata);
    assign tail_add = (r_ec && (32'(r_count) < MAX_SITES)) ? entry_m : '0;
    assign accept   = start && !busy;
    assign at_end   = r_time >= r_end_time;
    assign hop_site = cur_free && (cur_pos < sc);
    assign base_dec = (r_base == '0) ? IW'(MAX_SITES - 1) : r_base - IW'(1);
    assign sh_last  = ((CW+1)'(r_i) + (CW+1)'(1)) >= (CW+1)'(r_count);
    assign free_cmp = !((32'(r_cur_pos) + 32'(r_gap)) >= 32'(cur_pos));
    assign time_sum = {1'b0, r_time} + 49'(div_quot);
    assign busy     = (r_state != tgs_pkg::ST_IDLE);

    // pending flag refreshes, lowest slot first
    always_comb begin
        rf_any = 1'b1;
        rf_k   = 2'd0;
        if (r_rf_vld[0])      rf_k = 2'd0;
        else if (r_rf_vld[1]) rf_k = 2'd1;
        else if (r_rf_vld[2]) rf_k = 2'd2;
        else                  rf_any = 1'b0;
    end
    assign rf_sel = r_rf_idx[rf_k];

    tgs_div #(
        .NW (32),
        .DW (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_exp, 8'd0}),
        .i_den   (r_acc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tgs_pkg::ST_IDLE: begin
                if (accept) n_state = (i_op == tgs_pkg::OP_STEP) ? tgs_pkg::ST_P_RD
                                                                 : tgs_pkg::ST_DONE;
            end
            tgs_pkg::ST_P_RD: begin
                if (r_i != r_count)  n_state = tgs_pkg::ST_P_PD;
                else if (!r_pass)    n_state = tgs_pkg::ST_CHECK;
                else                 n_state = tgs_pkg::ST_INS;
            end
            tgs_pkg::ST_P_PD: begin
                if (!cur_free)       n_state = tgs_pkg::ST_P_RD;
                else if (hop_site)   n_state = tgs_pkg::ST_P_RT;
                else if (r_pass && (hit(r_target, cum1) || (ec_now && hit(r_target, cum2))))
                                     n_state = tgs_pkg::ST_SH_RD;
                else                 n_state = tgs_pkg::ST_P_RD;
            end
            tgs_pkg::ST_P_RT: begin
                n_state = (r_pass && hit(r_target, acc_rt)) ? tgs_pkg::ST_HOP_WR
                                                            : tgs_pkg::ST_P_RD;
            end
            tgs_pkg::ST_CHECK: begin
                n_state = (at_end || r_acc == '0) ? tgs_pkg::ST_DONE : tgs_pkg::ST_DIV;
            end
            tgs_pkg::ST_DIV: begin
                if (div_done) n_state = tgs_pkg::ST_P_RD;
            end
            tgs_pkg::ST_HOP_WR: n_state = tgs_pkg::ST_RF_RD0;
            tgs_pkg::ST_SH_RD: begin
                if (!sh_last)                         n_state = tgs_pkg::ST_SH_WR;
                else if (r_kind == tgs_pkg::KIND_TERM) n_state = tgs_pkg::ST_RF_RD0;
                else                                  n_state = tgs_pkg::ST_INS;
            end
            tgs_pkg::ST_SH_WR: n_state = tgs_pkg::ST_SH_RD;
            tgs_pkg::ST_INS:   n_state = tgs_pkg::ST_RF_RD0;
            tgs_pkg::ST_RF_RD0: begin
                if (!rf_any)              n_state = tgs_pkg::ST_DONE;
                else if (rf_sel < r_count) n_state = tgs_pkg::ST_RF_RD1;
            end
            tgs_pkg::ST_RF_RD1: begin
                n_state = (r_rfi == r_count - CW'(1)) ? tgs_pkg::ST_RF_RD0
                                                      : tgs_pkg::ST_RF_CMP;
            end
            tgs_pkg::ST_RF_CMP: n_state = tgs_pkg::ST_RF_RD0;
            tgs_pkg::ST_DONE:   n_state = tgs_pkg::ST_IDLE;
            default:            n_state = tgs_pkg::ST_IDLE;
        endcase
    end

    // ---- memory port control ----
    always_comb begin
        p_re      = 1'b0;
        p_raddr   = '0;
        p_we      = 1'b0;
        p_waddr   = '0;
        p_wdata   = '0;
        rt_re     = 1'b0;
        rt_raddr  = cur_pos[IW-1:0];
        rt_we     = 1'b0;
        rt_waddr  = IW'(i_site_index);
        div_start = 1'b0;
        unique case (r_state)
            tgs_pkg::ST_IDLE: begin
                rt_we = accept && (i_op == tgs_pkg::OP_WRITE) &&
                        (32'(i_site_index) < MAX_SITES);
            end
            tgs_pkg::ST_P_RD: begin
                p_re    = (r_i != r_count);
                p_raddr = phys(r_base, r_i);
            end
            tgs_pkg::ST_P_PD:  rt_re = hop_site;
            tgs_pkg::ST_CHECK: div_start = !(at_end || r_acc == '0);
            tgs_pkg::ST_HOP_WR: begin
                p_we    = 1'b1;
                p_waddr = phys(r_base, r_p);
                p_wdata = {r_cur_free, r_cur_pos + CW'(1)};
            end
            tgs_pkg::ST_SH_RD: begin
                p_re    = !sh_last;
                p_raddr = phys(r_base, r_i + CW'(1));
            end
            tgs_pkg::ST_SH_WR: begin
                p_we    = 1'b1;
                p_waddr = phys(r_base, r_i);
                p_wdata = r_pdata;
            end
            tgs_pkg::ST_INS: begin
                p_we    = 1'b1;
                p_waddr = base_dec;
                p_wdata = {1'b1, CW'(1)};
            end
            tgs_pkg::ST_RF_RD0: begin
                p_re    = rf_any && (rf_sel < r_count);
                p_raddr = phys(r_base, rf_sel);
            end
            tgs_pkg::ST_RF_RD1: begin
                // the last particle is always free
                if (r_rfi == r_count - CW'(1)) begin
                    p_we    = 1'b1;
                    p_waddr = phys(r_base, r_rfi);
                    p_wdata = {1'b1, cur_pos};
                end else begin
                    p_re    = 1'b1;
                    p_raddr = phys(r_base, r_rfi + CW'(1));
                end
            end
            tgs_pkg::ST_RF_CMP: begin
                p_we    = 1'b1;
                p_waddr = phys(r_base, r_rfi);
                p_wdata = {free_cmp, r_cur_pos};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) r_pmem[p_waddr] <= p_wdata;
        if (p_re) r_pdata <= r_pmem[p_raddr];
        if (rt_we) r_rmem[rt_waddr] <= i_site_rate[RW-1:0];
        if (rt_re) r_rdata <= r_rmem[rt_raddr];
    end

    // ---- datapath and run state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tgs_pkg::ST_IDLE;
            r_count        <= '0;
            r_time         <= '0;
            r_yield        <= '0;
            r_base         <= '0;
            r_rf_vld       <= '0;
            o_valid        <= 1'b0;
            r_entry_rate   <= 16'd256;
            r_exit_rate    <= 16'd256;
            r_recycle_rate <= 16'd0;
            r_gap          <= 6'd1;
            r_site_count   <= 11'd1024;
            r_end_time     <= 48'd65536000;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tgs_pkg::CFG_ENTRY:   r_entry_rate   <= i_cfg_data[15:0];
                    tgs_pkg::CFG_EXIT:    r_exit_rate    <= i_cfg_data[15:0];
                    tgs_pkg::CFG_RECYCLE: r_recycle_rate <= i_cfg_data[15:0];
                    tgs_pkg::CFG_GAP:     r_gap          <= i_cfg_data[5:0];
                    tgs_pkg::CFG_SITES:   r_site_count   <= i_cfg_data[10:0];
                    tgs_pkg::CFG_END:     r_end_time     <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                tgs_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_u     <= i_uniform_draw;
                        r_exp   <= i_exp_draw;
                        r_kind  <= tgs_pkg::KIND_NONE;
                        r_moved <= '0;
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_pass  <= 1'b0;
                        r_ec    <= (r_count == '0);
                        if (i_op == tgs_pkg::OP_START) begin
                            r_count <= '0;
                            r_time  <= '0;
                            r_yield <= '0;
                        end
                    end
                end
                tgs_pkg::ST_P_RD: begin
                    // past the last particle: initiation candidate
                    if (r_i == r_count) begin
                        if (!r_pass) r_acc  <= r_acc + tail_add;
                        else         r_kind <= tgs_pkg::KIND_INIT;
                    end
                end
                tgs_pkg::ST_P_PD: begin
                    r_cur_pos  <= cur_pos;
                    r_cur_free <= cur_free;
                    if (r_i == '0) r_ec <= ec_now;
                    if (!cur_free) begin
                        r_i <= r_i + CW'(1);
                    end else if (!hop_site) begin
                        // at the last site: termination, then recycling
                        if (r_pass && hit(r_target, cum1)) begin
                            r_kind <= tgs_pkg::KIND_TERM;
                            r_p    <= r_i;
                        end else if (r_pass && ec_now && hit(r_target, cum2)) begin
                            r_kind <= tgs_pkg::KIND_RECYCLE;
                            r_p    <= r_i;
                        end else begin
                            r_acc <= cum2;
                            r_i   <= r_i + CW'(1);
                        end
                        if (r_pass && (hit(r_target, cum1) || (ec_now && hit(r_target, cum2))))
                            r_yield <= (r_yield == 32'hFFFF_FFFF) ? r_yield
                                                                  : r_yield + 32'd1;
                    end
                end
                tgs_pkg::ST_P_RT: begin
                    if (r_pass && hit(r_target, acc_rt)) begin
                        r_kind <= tgs_pkg::KIND_HOP;
                        r_p    <= r_i;
                    end else begin
                        r_acc <= acc_rt;
                        r_i   <= r_i + CW'(1);
                    end
                end
                tgs_pkg::ST_CHECK: begin
                    if (at_end || r_acc == '0) begin
                        r_kind <= tgs_pkg::KIND_OVER;
                    end else begin
                        r_target <= MW'(r_u) * MW'(r_acc);
                    end
                end
                tgs_pkg::ST_DIV: begin
                    if (div_done) begin
                        r_time <= time_sum[48] ? TIME_MAX : time_sum[47:0];
                        r_acc  <= '0;
                        r_i    <= '0;
                        r_pass <= 1'b1;
                    end
                end
                tgs_pkg::ST_HOP_WR: begin
                    r_moved     <= 11'(r_cur_pos + CW'(1));
                    r_rf_idx[0] <= r_p;
                    r_rf_idx[1] <= r_p - CW'(1);   // wraps high for the first particle
                    r_rf_vld    <= 3'b011;
                end
                tgs_pkg::ST_SH_RD: begin
                    if (sh_last) begin
                        r_count <= r_count - CW'(1);
                        if (r_kind == tgs_pkg::KIND_TERM) begin
                            r_rf_idx[0] <= r_p - CW'(1);
                            r_rf_idx[1] <= r_count - CW'(2);
                            r_rf_vld    <= 3'b011;
                        end
                    end
                end
                tgs_pkg::ST_SH_WR: r_i <= r_i + CW'(1);
                tgs_pkg::ST_INS: begin
                    r_base      <= base_dec;
                    r_count     <= r_count + CW'(1);
                    r_rf_idx[0] <= '0;
                    r_rf_idx[1] <= r_p;
                    r_rf_idx[2] <= r_count;        // new last particle
                    r_rf_vld    <= (r_kind == tgs_pkg::KIND_INIT) ? 3'b001 : 3'b111;
                end
                tgs_pkg::ST_RF_RD0: begin
                    if (rf_any) begin
                        r_rf_vld[rf_k] <= 1'b0;
                        r_rfi          <= rf_sel;
                    end
                end
                tgs_pkg::ST_RF_RD1: r_cur_pos <= cur_pos;
                tgs_pkg::ST_RF_CMP: ;
                tgs_pkg::ST_DONE: begin
                    o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result registers, loaded as the strobe rises
    always_ff @(posedge i_clk) begin
        if (r_state == tgs_pkg::ST_DONE) begin
            o_reaction_kind  <= r_kind;
            o_moved_position <= r_moved;
            o_particle_count <= 11'(r_count);
            o_yield_total    <= r_yield;
            o_sim_time       <= r_time;
            o_run_done       <= (r_kind == tgs_pkg::KIND_OVER) || at_end;
        end
    end

endmodule
`default_nettype wire

[test/tasep_gillespie_event_step_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasep_gillespie_event_step_unit_tb
// Self-checking bench for the exclusion-process event engine. Requests are
// queued by the stimulus process, issued by a clocked driver with random
// gaps, and every result is checked field by field against a behavioral
// copy of the engine kept in this file.
// ----------------------------------------------------------------------------
module tasep_gillespie_event_step_unit_tb;
    import tgs_pkg::*;

    localparam int      NSITES     = 1024;
    localparam longint  CYCLE_CAP  = 8000000;
    localparam longint unsigned TIME_TOP = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [15:0] rate;
        logic [15:0] uni;
        logic [23:0] expd;
    } req_t;

    typedef struct {
        logic [2:0]  kind;
        logic [10:0] moved;
        logic [10:0] count;
        logic [31:0] yld;
        logic [47:0] t;
        logic        done;
    } evt_t;

    // DUT inputs, all driven to known values from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [9:0]  i_site_index = '0;
    logic [15:0] i_site_rate = '0;
    logic [15:0] i_uniform_draw = '0;
    logic [23:0] i_exp_draw = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [47:0] i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_reaction_kind;
    logic [10:0] o_moved_position;
    logic [10:0] o_particle_count;
    logic [31:0] o_yield_total;
    logic [47:0] o_sim_time;
    logic        o_run_done;

    tasep_gillespie_event_step_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_site_index     (i_site_index),
        .i_site_rate      (i_site_rate),
        .i_uniform_draw   (i_uniform_draw),
        .i_exp_draw       (i_exp_draw),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_reaction_kind  (o_reaction_kind),
        .o_moved_position (o_moved_position),
        .o_particle_count (o_particle_count),
        .o_yield_total    (o_yield_total),
        .o_sim_time       (o_sim_time),
        .o_run_done       (o_run_done)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Engine state as predicted by the bench
    // ------------------------------------------------------------------
    logic [15:0] hop_rate [NSITES];
    int          lane_pos [NSITES];   // particle positions, entry side first
    bit          lane_free[NSITES];
    int          n_on_lane;
    longint unsigned clock_now;       // 32.16 simulated time
    logic [31:0] exit_tally;

    // configuration copy
    logic [15:0] cf_entry = 16'd256;
    logic [15:0] cf_exit  = 16'd256;
    logic [15:0] cf_recyc = 16'd0;
    int          cf_gap   = 1;
    int          cf_sites = 1024;
    longint unsigned cf_end = 64'd65536000;

    // candidate list built per event
    logic [2:0]      cand_kind [2*NSITES+1];
    int              cand_part [2*NSITES+1];
    longint unsigned cand_rate [2*NSITES+1];

    req_t req_q[$];         // requests not yet issued
    evt_t event_q[$];       // predicted results, oldest first

    int     err_cnt = 0;
    int     snd_idle_pct = 26;
    longint cyc = 0;

    // blocked when left position plus gap reaches the right one; last always free
    function automatic void refresh_flag(int i);
        if (i >= n_on_lane) return;
        if (i + 1 == n_on_lane) lane_free[i] = 1'b1;
        else lane_free[i] = !(lane_pos[i] + cf_gap >= lane_pos[i+1]);
    endfunction

    function automatic void drop_particle(int p);
        for (int j = p; j < n_on_lane - 1; j++) begin
            lane_pos[j]  = lane_pos[j+1];
            lane_free[j] = lane_free[j+1];
        end
        n_on_lane--;
    endfunction

    function automatic void push_front_particle();
        for (int j = n_on_lane; j > 0; j--) begin
            lane_pos[j]  = lane_pos[j-1];
            lane_free[j] = lane_free[j-1];
        end
        lane_pos[0]  = 1;
        lane_free[0] = 1'b1;
        n_on_lane++;
    endfunction

    function automatic void bump_tally();
        if (exit_tally != 32'hFFFF_FFFF) exit_tally++;
    endfunction

    // Applies one request to the predicted state and returns its result
    function automatic evt_t predict_event(req_t r);
        evt_t            e;
        longint unsigned total, tau, target, cum;
        int              n, sc, c, p;
        bit              clear;
        e.kind  = KIND_NONE;
        e.moved = '0;
        if (r.op == OP_WRITE) begin
            hop_rate[r.idx] = r.rate;
        end else if (r.op == OP_START) begin
            n_on_lane  = 0;
            clock_now  = 0;
            exit_tally = '0;
        end else if (r.op == OP_STEP) begin
            sc    = (cf_sites == 0) ? 1 : ((cf_sites > NSITES) ? NSITES : cf_sites);
            clear = (n_on_lane == 0) || (cf_gap < lane_pos[0]);
            n     = 0;
            total = 0;
            for (int i = 0; i < n_on_lane; i++) begin
                if (lane_free[i]) begin
                    if (lane_pos[i] < sc) begin
                        cand_kind[n] = KIND_HOP;
                        cand_part[n] = i;
                        cand_rate[n] = hop_rate[lane_pos[i] % NSITES];
                        total += cand_rate[n];
                        n++;
                    end else begin
                        cand_kind[n] = KIND_TERM;
                        cand_part[n] = i;
                        cand_rate[n] = cf_exit;
                        total += cand_rate[n];
                        n++;
                        if (clear) begin
                            cand_kind[n] = KIND_RECYCLE;
                            cand_part[n] = i;
                            cand_rate[n] = cf_recyc;
                            total += cand_rate[n];
                            n++;
                        end
                    end
                end
            end
            if (clear && n_on_lane < NSITES) begin
                cand_kind[n] = KIND_INIT;
                cand_part[n] = 0;
                cand_rate[n] = cf_entry;
                total += cand_rate[n];
                n++;
            end
            if (clock_now >= cf_end || total == 0) begin
                e.kind = KIND_OVER;
            end else begin
                tau    = (longint'(r.expd) << 8) / total;
                target = longint'(r.uni) * total;
                cum    = 0;
                c      = 0;
                clock_now = (TIME_TOP - clock_now < tau) ? TIME_TOP : clock_now + tau;
                for (int i = 0; i < n; i++) begin
                    cum += cand_rate[i];
                    if (target < (cum << 16)) begin
                        c = i;
                        break;
                    end
                end
                e.kind = cand_kind[c];
                p      = cand_part[c];
                if (e.kind == KIND_HOP) begin
                    lane_pos[p]++;
                    e.moved = lane_pos[p];
                    refresh_flag(p);
                    if (p > 0) refresh_flag(p - 1);
                end else if (e.kind == KIND_INIT) begin
                    push_front_particle();
                    refresh_flag(0);
                end else if (e.kind == KIND_RECYCLE) begin
                    drop_particle(p);
                    push_front_particle();
                    refresh_flag(0);
                    refresh_flag(p);
                    if (n_on_lane > 0) refresh_flag(n_on_lane - 1);
                    bump_tally();
                end else begin
                    drop_particle(p);
                    if (p > 0) refresh_flag(p - 1);
                    if (n_on_lane > 0) refresh_flag(n_on_lane - 1);
                    bump_tally();
                end
            end
        end
        e.count = n_on_lane;
        e.yld   = exit_tally;
        e.t     = clock_now;
        e.done  = (e.kind == KIND_OVER) || (clock_now >= cf_end);
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Driver: issues queued requests; a request is taken at start & !busy
    // ------------------------------------------------------------------
    req_t cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                event_q.push_back(predict_event(cur_req));
            if (!start || !busy) begin
                // slot is free: either idle this cycle or present the next one
                if (req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    cur_req        = req_q.pop_front();
                    start          <= 1'b1;
                    i_op           <= cur_req.op;
                    i_site_index   <= cur_req.idx;
                    i_site_rate    <= cur_req.rate;
                    i_uniform_draw <= cur_req.uni;
                    i_exp_draw     <= cur_req.expd;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result is matched against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        evt_t w;
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && o_valid) begin
            if (event_q.size() == 0) begin
                report("unexpected result", o_reaction_kind, 0);
            end else begin
                w = event_q.pop_front();
                if (o_reaction_kind !== w.kind)   report("reaction_kind", o_reaction_kind, w.kind);
                if (o_moved_position !== w.moved) report("moved_position", o_moved_position, w.moved);
                if (o_particle_count !== w.count) report("particle_count", o_particle_count, w.count);
                if (o_yield_total !== w.yld)      report("yield_total", o_yield_total, w.yld);
                if (o_sim_time !== w.t)           report("sim_time", o_sim_time, w.t);
                if (o_run_done !== w.done)        report("run_done", o_run_done, w.done);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic req_t mk_req(logic [1:0] op, int idx, int rate, int uni, int expd);
        req_t r;
        r.op   = op;
        r.idx  = idx;
        r.rate = rate;
        r.uni  = uni;
        r.expd = expd;
        return r;
    endfunction

    // mostly simulate steps with modest exponential draws so runs last a while
    function automatic req_t rand_req();
        req_t r;
        int   sel;
        sel    = $urandom_range(0, 99);
        r.idx  = $urandom_range(0, NSITES - 1);
        r.rate = ($urandom_range(0, 9) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
        r.uni  = $urandom_range(0, 65535);
        r.expd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                            : $urandom_range(0, 262143);
        if (sel < 72)      r.op = OP_STEP;
        else if (sel < 79) r.op = OP_START;
        else if (sel < 95) r.op = OP_WRITE;
        else               r.op = 2'd3;
        return r;
    endfunction

    // blocks until every request has been issued and answered
    task automatic wait_idle();
        do @(posedge i_clk);
        while (req_q.size() != 0 || event_q.size() != 0 || start || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, longint unsigned data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[47:0];
        case (idx)
            CFG_ENTRY:   cf_entry = data[15:0];
            CFG_EXIT:    cf_exit  = data[15:0];
            CFG_RECYCLE: cf_recyc = data[15:0];
            CFG_GAP:     cf_gap   = data[5:0];
            CFG_SITES:   cf_sites = data[10:0];
            CFG_END:     cf_end   = data[47:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(int en, int ex, int rc, int gp, int st, longint unsigned et);
        cfg_write(CFG_ENTRY, en);
        cfg_write(CFG_EXIT, ex);
        cfg_write(CFG_RECYCLE, rc);
        cfg_write(CFG_GAP, gp);
        cfg_write(CFG_SITES, st);
        cfg_write(CFG_END, et);
    endtask

    task automatic random_phase(int n_items, bit fresh_run);
        if (fresh_run) req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        repeat (n_items) req_q.push_back(rand_req());
        wait_idle();
    endtask

    initial begin
        n_on_lane  = 0;
        clock_now  = 0;
        exit_tally = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // whole rate table is written first so no step reads an unwritten site
        for (int s = 0; s < NSITES; s++)
            req_q.push_back(mk_req(OP_WRITE, s, $urandom_range(1, 65535), 0, 0));
        wait_idle();

        // directed: reset-time config, every op, draw extremes, table extremes
        req_q.push_back(mk_req(2'd3, 0, 0, 0, 0));
        req_q.push_back(mk_req(OP_STEP, 0, 0, 0, 0));
        req_q.push_back(mk_req(OP_STEP, 0, 0, 65535, 24'hFFFFFF));
        req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        req_q.push_back(mk_req(OP_WRITE, 1023, 65535, 0, 0));
        req_q.push_back(mk_req(OP_WRITE, 0, 0, 0, 0));
        for (int k = 0; k < 10; k++)
            req_q.push_back(mk_req(OP_STEP, 0, 0, (k & 1) ? 65535 : 0, 65536));
        req_q.push_back(mk_req(2'd3, 1023, 65535, 65535, 24'hFFFFFF));
        wait_idle();

        // end time zero: run is over before anything happens
        cfg_write(CFG_END, 0);
        req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        req_q.push_back(mk_req(OP_STEP, 0, 0, 1234, 4321));
        wait_idle();

        // tiny lattice, recycling, then an event that carries time past the end
        load_cfg(256, 256, 65535, 0, 0, 64'd70000);
        req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        for (int k = 0; k < 6; k++)
            req_q.push_back(mk_req(OP_STEP, 0, 0, 32768, 30000));
        wait_idle();

        // full lattice: zero gap stacks particles at the entry site, only the
        // last one is free; site one gets rate zero so initiation runs out
        load_cfg(65535, 0, 0, 0, 1024, 64'hFFFF_FFFF_FFFF);
        req_q.push_back(mk_req(OP_WRITE, 1, 0, 0, 0));
        req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        repeat (NSITES + 4) req_q.push_back(mk_req(OP_STEP, 0, 0, $urandom_range(0, 65535), 1));
        req_q.push_back(mk_req(OP_WRITE, 1, 512, 0, 0));
        req_q.push_back(mk_req(OP_START, 0, 0, 0, 0));
        wait_idle();

        // random rounds: sender idle 26%, then 67%, then never
        for (int rnd = 0; rnd < 3; rnd++) begin
            snd_idle_pct = (rnd == 0) ? 26 : ((rnd == 1) ? 67 : 0);

            load_cfg(256, 256, 128, 1, $urandom_range(4, 24), 64'd65536000);
            random_phase(70, 1'b1);

            load_cfg(65535, 0, 65535, 0, 0, 64'hFFFF_FFFF_FFFF);
            random_phase(70, $urandom_range(0, 1));

            // oversized lattice acts as the maximum, widest gap
            load_cfg(0, 65535, 0, 63, 2047, 64'd1 << 24);
            random_phase(70, 1'b1);

            load_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 5),
                     $urandom_range(2, 40), $urandom_range(0, 32'h0FFF_FFFF));
            random_phase(70, $urandom_range(0, 1));

            load_cfg($urandom_range(1, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 3),
                     $urandom_range(1, 64), 64'd65536000);
            random_phase(70, 1'b1);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
